// ===== src/dtyp_pkg.sv =====
`timescale 1ns / 1ps
package dtyp_pkg;

  // CORDIC datapath width: operands normalized below 2^59, growth stays under 2^61
  localparam int unsigned CW = 62;
  // angle accumulator, signed Q.32 degrees
  localparam int unsigned AW = 40;
  localparam int unsigned MAX_STEPS = 32;

  localparam logic [24:0] DEG_90  = 25'd5898240;
  localparam logic [24:0] DEG_180 = 25'd11796480;
  localparam logic [24:0] DEG_270 = 25'd17694720;
  localparam logic [24:0] DEG_360 = 25'd23592960;
  localparam logic [AW-1:0] Q32_90 = 40'd386547056640;

  typedef logic [AW-1:0] atan_tab_t [MAX_STEPS];

  // atan(2^-i) in Q.32 degrees
  localparam atan_tab_t ATAN_TAB = '{
    40'd193273528320, 40'd114096026022, 40'd60285206653, 40'd30601712202,
    40'd15360239180, 40'd7687607529, 40'd3844741808, 40'd1922488225,
    40'd961258780, 40'd480631223, 40'd240315841, 40'd120157949,
    40'd60079956, 40'd30039978, 40'd15019989, 40'd7509995,
    40'd3754997, 40'd1877499, 40'd938749, 40'd469375,
    40'd234687, 40'd117344, 40'd58672, 40'd29336,
    40'd14668, 40'd7334, 40'd3667, 40'd1833,
    40'd917, 40'd458, 40'd229, 40'd115
  };

  // sideband carried alongside the CORDIC pipelines
  typedef struct packed {
    logic xy_zero;
    logic x_zero;
    logic x_neg;
    logic y_neg;
    logic y_pos;
    logic z_neg;
    logic z_pos;
  } side_t;

endpackage

// ===== src/dtyp_atan.sv =====
`timescale 1ns / 1ps
// Pipelined first-quadrant atan(b/a): normalize stages, min(STEPS,32) CORDIC
// stages, clamp and round. Advances on en; valid tracking is left to the parent.
module dtyp_atan #(
  parameter int unsigned STEPS = 24
) (
  input  logic        clk,
  input  logic        en,
  input  logic [33:0] in_a,
  input  logic [33:0] in_b,
  output logic [22:0] ang   // Q.16 degrees, [0,90]
);
  import dtyp_pkg::*;

  localparam int unsigned N = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;

  // normalization: two stages (shift amount with inputs, then the shift)
  logic [33:0] m;
  logic [5:0]  lz;
  logic [33:0] a0_r, b0_r;
  logic [5:0]  sh0_r;
  logic [CW-1:0] x_r [N+1];
  logic [CW-1:0] y_r [N+1];
  logic [AW-1:0] z_r [N+1];
  logic [AW-1:0] zc;
  logic [AW-1:0] zc_r;
  logic [AW-1:0] zrnd;

  assign m = (in_a > in_b) ? in_a : in_b;

  // leading-zero count over 34 bits; shift so max lands in [2^58,2^59)
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 34; i++) begin
      if (m[i]) lz = 6'(33 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r  <= in_a;
      b0_r  <= in_b;
      sh0_r <= (m == '0) ? 6'd0 : 6'(lz + 6'd25);
    end
  end

  // zero max does not give zero angle: x, y stay zero but z still accumulates
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= {{(CW-34){1'b0}}, a0_r} << sh0_r;
      y_r[0] <= {{(CW-34){1'b0}}, b0_r} << sh0_r;
      z_r[0] <= '0;
    end
  end

  // vectoring stages
  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [CW-1:0] dx, dy;
    assign dx = CW'($signed(y_r[g]) >>> g);
    assign dy = CW'($signed(x_r[g]) >>> g);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[g][CW-1]) begin
          x_r[g+1] <= x_r[g] + dx;
          y_r[g+1] <= y_r[g] - dy;
          z_r[g+1] <= z_r[g] + ATAN_TAB[g];
        end else begin
          x_r[g+1] <= x_r[g] - dx;
          y_r[g+1] <= y_r[g] + dy;
          z_r[g+1] <= z_r[g] - ATAN_TAB[g];
        end
      end
    end
  end

  // clamp to [0,90] Q.32
  always_comb begin
    if (z_r[N][AW-1])            zc = '0;
    else if (z_r[N] > Q32_90)    zc = Q32_90;
    else                         zc = z_r[N];
  end

  always_ff @(posedge clk) begin
    if (en) zc_r <= zc;
  end

  assign zrnd = (zc_r + AW'(32768)) >> 16;
  assign ang  = (zrnd > AW'(DEG_90)) ? DEG_90[22:0] : zrnd[22:0];

endmodule

// ===== src/dtyp_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined floor(sqrt(x^2+y^2)): squares in two 32x32 products, one stage
// per result bit (32 restoring steps).
module dtyp_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] in_ax,   // |x|, up to 2^31
  input  logic [31:0] in_ay,   // |y|, up to 2^31
  output logic [32:0] root
);
  // magnitudes are up to 2^31, so 32 bits hold them
  logic [63:0] sqx_r, sqy_r;
  logic [63:0] s_r [33];
  logic [32:0] q_r [33];
  logic [65:0] rm_r [33];

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= 64'(in_ax) * 64'(in_ax);
      sqy_r <= 64'(in_ay) * 64'(in_ay);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0]  <= sqx_r + sqy_r;
      q_r[0]  <= '0;
      rm_r[0] <= '0;
    end
  end

  // restoring square root, two radicand bits per stage
  for (genvar g = 0; g < 32; g++) begin : g_sq
    logic [65:0] trial, cur;
    assign cur   = {rm_r[g][63:0], s_r[g][63:62]};
    assign trial = {31'd0, q_r[g], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[g+1] <= s_r[g] << 2;
        if (cur >= trial) begin
          rm_r[g+1] <= cur - trial;
          q_r[g+1]  <= {q_r[g][31:0], 1'b1};
        end else begin
          rm_r[g+1] <= cur;
          q_r[g+1]  <= {q_r[g][31:0], 1'b0};
        end
      end
    end
  end

  assign root = q_r[32];

endmodule

// ===== src/direction_to_yaw_pitch_core.sv =====
`timescale 1ns / 1ps
// The square-root stages (34) precede the pitch CORDIC.
// Throughput: one vector per clock; the whole pipeline holds on a stall.
// Reset: rst_n (synchronous, active low) clears all stage valid bits.
module direction_to_yaw_pitch_core #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [24:0] out_yaw_deg,
  output logic signed [25:0] out_pitch_deg
);
  import dtyp_pkg::*;

  localparam int unsigned N   = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int unsigned LA  = N + 3;          // atan unit latency
  localparam int unsigned LS  = 34;             // sqrt unit latency
  localparam int unsigned LAT = 1 + LS + LA;    // input reg + sqrt + atan

  logic en;
  logic [LAT-1:0] v_r;

  // advance whenever the final stage is empty or being drained
  assign en       = !v_r[LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  // input stage: magnitudes and flags
  logic [32:0] ax_r, ay_r, az_r;
  side_t sd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= in_dir_x[31] ? 33'(-{in_dir_x[31], in_dir_x}) : 33'({1'b0, in_dir_x});
      ay_r <= in_dir_y[31] ? 33'(-{in_dir_y[31], in_dir_y}) : 33'({1'b0, in_dir_y});
      az_r <= in_dir_z[31] ? 33'(-{in_dir_z[31], in_dir_z}) : 33'({1'b0, in_dir_z});
      sd_r.xy_zero <= (in_dir_x == '0) && (in_dir_y == '0);
      sd_r.x_zero  <= (in_dir_x == '0);
      sd_r.x_neg   <= in_dir_x[31];
      sd_r.y_neg   <= in_dir_y[31];
      sd_r.y_pos   <= !in_dir_y[31] && (in_dir_y != '0);
      sd_r.z_neg   <= in_dir_z[31];
      sd_r.z_pos   <= !in_dir_z[31] && (in_dir_z != '0);
    end
  end

  // horizontal length (|v| = 2^31 is exact in the low 32 bits)
  logic [32:0] r;
  dtyp_isqrt u_sqrt (
    .clk(clk), .en(en),
    .in_ax(ax_r[31:0]),
    .in_ay(ay_r[31:0]),
    .root(r)
  );

  // delay line aligning yaw operands and z with the root
  logic [32:0] axd_r [LS];
  logic [32:0] ayd_r [LS];
  logic [32:0] azd_r [LS];
  always_ff @(posedge clk) begin
    if (en) begin
      axd_r[0] <= ax_r;
      ayd_r[0] <= ay_r;
      azd_r[0] <= az_r;
      for (int i = 1; i < LS; i++) begin
        axd_r[i] <= axd_r[i-1];
        ayd_r[i] <= ayd_r[i-1];
        azd_r[i] <= azd_r[i-1];
      end
    end
  end

  // yaw and pitch CORDICs run in parallel after the root
  logic [22:0] yaw_a, pit_a;
  dtyp_atan #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en),
    .in_a({1'b0, axd_r[LS-1]}), .in_b({1'b0, ayd_r[LS-1]}), .ang(yaw_a)
  );
  dtyp_atan #(.STEPS(CORDIC_STEPS)) u_pit (
    .clk(clk), .en(en),
    .in_a({1'b0, r}), .in_b({1'b0, azd_r[LS-1]}), .ang(pit_a)
  );

  // flags follow the whole path
  side_t sdd_r [LS+LA];
  always_ff @(posedge clk) begin
    if (en) begin
      sdd_r[0] <= sd_r;
      for (int i = 1; i < LS + LA; i++) sdd_r[i] <= sdd_r[i-1];
    end
  end

  side_t s;
  logic [24:0] ya, pa;
  assign s  = sdd_r[LS+LA-1];
  assign ya = {2'b00, yaw_a};
  assign pa = {2'b00, pit_a};

  // quadrant fold
  always_comb begin
    if (s.xy_zero) begin
      out_yaw_deg   = '0;
      out_pitch_deg = s.z_pos ? -$signed({1'b0, DEG_90}) : -$signed({1'b0, DEG_270});
    end else begin
      if (s.x_zero)                    out_yaw_deg = s.y_pos ? DEG_90 : DEG_270;
      else if (!s.x_neg && !s.y_neg)   out_yaw_deg = ya;
      else if (s.x_neg && !s.y_neg)    out_yaw_deg = DEG_180 - ya;
      else if (s.x_neg)                out_yaw_deg = DEG_180 + ya;
      else                             out_yaw_deg = (ya != '0) ? DEG_360 - ya : '0;
      if (!s.z_neg)        out_pitch_deg = -$signed({1'b0, pa});
      else if (pa != '0)   out_pitch_deg = $signed({1'b0, pa}) - $signed({1'b0, DEG_360});
      else                 out_pitch_deg = '0;
    end
  end

endmodule

// ===== tb/sv/direction_to_yaw_pitch_core_test.sv =====
`timescale 1ns / 1ps
module direction_to_yaw_pitch_core_test;

  localparam int unsigned STEPS = 24;
  localparam int unsigned LAT = 39 + STEPS;

  // angle scoreboard: predicts yaw/pitch per accepted vector, checks in order
  class angle_scoreboard;
    logic [24:0] yaw_q[$];
    logic [25:0] pitch_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    static function longint unsigned root_floor(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s = s - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // first-quadrant vectoring CORDIC, Q.16 degrees in [0,90]
    static function longint quad_angle(longint unsigned a, longint unsigned b);
      longint unsigned m;
      longint cx, cy, acc, dx, dy;
      int n;
      m = (a > b) ? a : b;
      acc = 0;
      n = (STEPS > 32) ? 32 : STEPS;
      if (m == 0) return 0;
      while (m < (64'd1 << 58)) begin
        m = m << 1;
        a = a << 1;
        b = b << 1;
      end
      cx = longint'(a);
      cy = longint'(b);
      for (int i = 0; i < n; i++) begin
        dx = floor_shr(cy, i);
        dy = floor_shr(cx, i);
        if (cy >= 0) begin
          cx += dx; cy -= dy; acc += longint'(dtyp_pkg::ATAN_TAB[i]);
        end else begin
          cx -= dx; cy += dy; acc -= longint'(dtyp_pkg::ATAN_TAB[i]);
        end
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(dtyp_pkg::Q32_90)) acc = longint'(dtyp_pkg::Q32_90);
      acc = (acc + 32768) >>> 16;
      if (acc > longint'(dtyp_pkg::DEG_90)) acc = longint'(dtyp_pkg::DEG_90);
      return acc;
    endfunction

    function void note_vector(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
      longint yaw, pitch, a, p;
      longint unsigned ax, ay, az, r;
      if (x == 0 && y == 0) begin
        yaw = 0;
        pitch = (z > 0) ? -longint'(dtyp_pkg::DEG_90) : -longint'(dtyp_pkg::DEG_270);
      end else begin
        ax = (x < 0) ? longint'(-longint'(x)) : longint'(x);
        ay = (y < 0) ? longint'(-longint'(y)) : longint'(y);
        az = (z < 0) ? longint'(-longint'(z)) : longint'(z);
        r = root_floor(ax * ax + ay * ay);
        if (x == 0) begin
          yaw = (y > 0) ? longint'(dtyp_pkg::DEG_90) : longint'(dtyp_pkg::DEG_270);
        end else begin
          a = quad_angle(ax, ay);
          if (x > 0 && y >= 0) yaw = a;
          else if (x < 0 && y >= 0) yaw = longint'(dtyp_pkg::DEG_180) - a;
          else if (x < 0) yaw = longint'(dtyp_pkg::DEG_180) + a;
          else yaw = (a > 0) ? longint'(dtyp_pkg::DEG_360) - a : 0;
        end
        p = quad_angle(r, az);
        if (z >= 0) pitch = -p;
        else pitch = (p > 0) ? p - longint'(dtyp_pkg::DEG_360) : 0;
      end
      yaw_q.push_back(yaw[24:0]);
      pitch_q.push_back(pitch[25:0]);
    endfunction

    function void check_angles(logic [24:0] yaw, logic [25:0] pitch);
      logic [24:0] ey;
      logic [25:0] ep;
      if (yaw_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer yaw=%0d pitch=%0d", yaw, pitch);
        return;
      end
      ey = yaw_q.pop_front();
      ep = pitch_q.pop_front();
      if (ey !== yaw || ep !== pitch) begin
        errors++;
        if (errors <= 10)
          $display("mismatch yaw exp=%0d got=%0d pitch exp=%0d got=%0d",
                   ey, yaw, $signed(ep), $signed(pitch));
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] in_dir_x, in_dir_y, in_dir_z;
  logic [24:0] out_yaw_deg;
  logic signed [25:0] out_pitch_deg;

  int send_idle_pct, recv_idle_pct;
  angle_scoreboard angles;

  direction_to_yaw_pitch_core #(.CORDIC_STEPS(STEPS)) dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: random stall, check on each transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      angles.check_angles(out_yaw_deg, out_pitch_deg);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid drops only while idling, so back-to-back vectors keep it high
  task automatic send_vector(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_dir_x <= x;
    in_dir_y <= y;
    in_dir_z <= z;
    do @(posedge clk); while (!in_ready);
    angles.note_vector(x, y, z);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(200)) - 100;
      3: return $signed($urandom) >>> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  localparam logic signed [31:0] MAXP = 32'sh7fffffff;
  localparam logic signed [31:0] MINN = 32'sh80000000;

  initial begin
    int wait_cnt;
    angles = new();
    in_valid = 0;
    in_dir_x = 0;
    in_dir_y = 0;
    in_dir_z = 0;
    out_ready = 0;
    send_idle_pct = 23;
    recv_idle_pct = 72;
    rst_n = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: zero horizontal, axis cases, quadrants, full scale
    send_vector(0, 0, 65536);
    send_vector(0, 0, 0);
    send_vector(0, 0, -65536);
    send_vector(0, 65536, 0);
    send_vector(0, -65536, 5);
    send_vector(65536, 0, 0);
    send_vector(-65536, 0, 0);
    send_vector(65536, 65536, 65536);
    send_vector(-65536, 65536, -65536);
    send_vector(-65536, -65536, 1);
    send_vector(65536, -65536, -1);
    send_vector(MAXP, -1, 0);
    send_vector(MAXP, 1, -1);
    send_vector(MINN, MINN, MINN);
    send_vector(MAXP, MAXP, MAXP);
    send_vector(MINN, MAXP, 0);
    send_vector(1, 1, MINN);
    send_vector(MINN, 0, MAXP);
    send_vector(-1, -1, -1);
    send_vector(32'shffffffff, 0, 32'sh7fff0000);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 72; recv_idle_pct = 23; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int i = 0; i < 545; i++) send_vector(rand_comp(), rand_comp(), rand_comp());
    end
    in_valid <= 0;

    wait_cnt = 0;
    while (angles.yaw_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LAT + 10) @(posedge clk);
    if (angles.errors == 0 && angles.yaw_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dtyp_pkg.sv
src/dtyp_atan.sv
src/dtyp_isqrt.sv
src/direction_to_yaw_pitch_core.sv
tb/sv/direction_to_yaw_pitch_core_test.sv
